@@ rtl/core/qss_pkg.sv @@
// Package for the quantized switch scheduler: constants, request type, queue entry.
// No dependencies.
package qss_pkg;
  localparam int unsigned TimeBits = 48;
  localparam int unsigned PidBits = 16;
  localparam int unsigned RateBits = 19;
  localparam logic [PidBits-1:0] NoPattern = 16'hFFFF;
  localparam logic [RateBits-1:0] DefaultRate = 19'd48000;
  localparam logic [15:0] DefaultTempo = 16'd7680;
  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  typedef enum logic [1:0] {
    QUANT_NONE = 2'd0,
    QUANT_BEAT = 2'd1,
    QUANT_BAR  = 2'd2,
    QUANT_BAR3 = 2'd3
  } quant_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_NOW    = 2'd2,
    CMD_ARM    = 2'd3
  } cmd_e;

  // Classified tick handed from the front to the back.
  typedef struct packed {
    cmd_e                 cmd;
    logic [PidBits-1:0]   target;
    logic                 bar;
    logic [TimeBits-1:0]  now;
    logic [15:0]          tempo;
    logic [7:0]           num;
    logic [7:0]           den;
    logic                 take;
  } tick_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_BEAT  = 3'd1,
    ST_BAR   = 3'd2,
    ST_REM   = 3'd3,
    ST_APPLY = 3'd4
  } back_e;
endpackage

@@ rtl/core/qss_front.sv @@
// Front: accepts ticks, classifies the request, holds a two-entry queue.
// Depends on qss_pkg.
module qss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                req_valid_i,
  input  logic [15:0]         req_target_i,
  input  logic [1:0]          req_quant_i,
  input  logic [47:0]         sample_time_i,
  input  logic                playing_i,
  input  logic [15:0]         tempo_bpm_i,
  input  logic [7:0]          sig_num_i,
  input  logic [7:0]          sig_den_i,
  input  logic                take_ready_i,
  output logic                q_valid_o,
  output qss_pkg::tick_t      q_tick_o,
  input  logic                q_pop_i
);
  import qss_pkg::*;
  tick_t  mem_q [2];
  logic   wr_q, rd_q;
  logic [1:0] cnt_q;
  tick_t  t;
  logic   wr_en, rd_en;

  always_comb begin
    t.target = req_target_i;
    t.bar    = (quant_e'(req_quant_i) != QUANT_BEAT);
    t.now    = sample_time_i;
    t.tempo  = tempo_bpm_i;
    t.num    = sig_num_i;
    t.den    = sig_den_i;
    t.take   = take_ready_i;
    if (!req_valid_i) t.cmd = CMD_NONE;
    else if (req_target_i == NoPattern) t.cmd = CMD_CANCEL;
    else if (quant_e'(req_quant_i) == QUANT_NONE || !playing_i) t.cmd = CMD_NOW;
    else t.cmd = CMD_ARM;
  end

  assign full = (cnt_q == 2'd2);
  assign wr_en = push && !full;
  assign rd_en = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_tick_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

@@ rtl/core/qss_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on qss_pkg.
module qss_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [47:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [47:0] rem_o
);
  import qss_pkg::*;
  logic [63:0] quo_q;
  logic [48:0] rem_q;
  logic [47:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [48:0] sh;
  logic        ge;

  assign sh = {rem_q[47:0], quo_q[63]};
  assign ge = (sh >= {1'b0, den_q});
  assign quo_o = quo_q;
  assign rem_o = rem_q[47:0];
  assign done_o = busy_q && (cnt_q == 7'd0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; rem_q <= '0; den_q <= den_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      rem_q <= ge ? (sh - {1'b0, den_q}) : sh;
      quo_q <= {quo_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 7'd1;
    end
  end
endmodule

@@ rtl/core/qss_back.sv @@
// Back: computes beat/bar and due time with a shared divider, updates state.
// Depends on qss_pkg, qss_div.
module qss_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [18:0]         rate_i,
  input  logic                q_valid_i,
  input  qss_pkg::tick_t      q_tick_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  output logic [15:0]         ready_target_o,
  output logic                is_armed_o,
  output logic [47:0]         due_time_o,
  input  logic                out_take_i
);
  import qss_pkg::*;
  back_e st_q, st_d;
  logic        armed_q, armed_d;
  logic [15:0] pend_q, pend_d, slot_q, slot_d;
  logic [47:0] due_q, due_d;
  logic [47:0] quant_q;
  logic        ovalid_q;
  logic [15:0] otgt_q;
  logic        oarm_q;
  logic [47:0] odue_q;
  logic        dstart;
  logic [63:0] dnum;
  logic [47:0] dden;
  logic        ddone;
  logic [63:0] dquo;
  logic [47:0] drem;
  logic [18:0] rate;
  logic [15:0] tmp;
  logic [7:0]  nn, dd;
  logic [47:0] beat, bar, add;
  logic        start_ok;

  qss_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
                 .done_o(ddone), .quo_o(dquo), .rem_o(drem));

  assign rate = (rate_i == '0) ? DefaultRate : rate_i;
  assign tmp  = (q_tick_i.tempo == '0) ? DefaultTempo : q_tick_i.tempo;
  assign nn   = (q_tick_i.num == '0) ? 8'd4 : q_tick_i.num;
  assign dd   = (q_tick_i.den == '0) ? 8'd4 : q_tick_i.den;
  assign beat = (dquo == '0) ? 48'd1 : dquo[47:0];
  assign bar  = (dquo == '0) ? 48'd1 : dquo[47:0];
  assign add  = quant_q - drem;
  // Output register free or being drained this cycle.
  assign start_ok = !ovalid_q || out_take_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (q_valid_i && start_ok)
                  st_d = (q_tick_i.cmd == CMD_ARM) ? ST_BEAT : ST_APPLY;
      ST_BEAT:  if (ddone) st_d = q_tick_i.bar ? ST_BAR : ST_REM;
      ST_BAR:   if (ddone) st_d = ST_REM;
      ST_REM:   if (ddone) st_d = ST_APPLY;
      ST_APPLY: st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dstart = 1'b0; dnum = '0; dden = '0;
    case (st_q)
      ST_IDLE: if (q_valid_i && start_ok && q_tick_i.cmd == CMD_ARM) begin
        dstart = 1'b1;
        dnum = 64'(({45'd0, rate} * 64'd7680) + {48'd0, tmp});
        dden = {31'd0, tmp, 1'b0};
      end
      ST_BEAT: if (ddone && q_tick_i.bar) begin
        // Scale the fresh beat length by 4 * numerator straight into the divider.
        dstart = 1'b1; dnum = 64'(beat * {nn, 2'b00}); dden = {40'd0, dd};
      end else if (ddone) begin
        dstart = 1'b1; dnum = {16'd0, q_tick_i.now}; dden = beat;
      end
      ST_BAR: if (ddone) begin
        dstart = 1'b1; dnum = {16'd0, q_tick_i.now}; dden = bar;
      end
      default: ;
    endcase
  end

  always_comb begin
    armed_d = armed_q; pend_d = pend_q; slot_d = slot_q; due_d = due_q;
    if (st_q == ST_APPLY) begin
      case (q_tick_i.cmd)
        CMD_CANCEL: begin armed_d = 1'b0; pend_d = NoPattern; slot_d = NoPattern; end
        CMD_NOW:    begin armed_d = 1'b0; pend_d = NoPattern; slot_d = q_tick_i.target; end
        CMD_ARM: begin
          armed_d = 1'b1; pend_d = q_tick_i.target;
          if (quant_q <= 48'd1 || drem == '0) due_d = q_tick_i.now;
          else if (add > TimeMax - q_tick_i.now) due_d = TimeMax;
          else due_d = q_tick_i.now + add;
        end
        default: ;
      endcase
      if (armed_d && q_tick_i.now >= due_d) begin
        slot_d = pend_d; armed_d = 1'b0; pend_d = NoPattern;
      end
    end
  end

  assign q_pop_o = (st_q == ST_APPLY);
  assign out_valid_o = ovalid_q;
  assign ready_target_o = otgt_q;
  assign is_armed_o = oarm_q;
  assign due_time_o = odue_q;

  always_ff @(posedge clk_i) begin
    if (st_q == ST_BEAT && ddone) quant_q <= beat;
    if (st_q == ST_BAR && ddone) quant_q <= bar;
    if (st_q == ST_APPLY) begin
      otgt_q <= slot_d;
      oarm_q <= armed_d;
      odue_q <= armed_d ? due_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; armed_q <= 1'b0; pend_q <= NoPattern;
      slot_q <= NoPattern; due_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_APPLY) begin
        armed_q <= armed_d; pend_q <= pend_d; due_q <= due_d;
        slot_q <= q_tick_i.take ? NoPattern : slot_d;
        ovalid_q <= 1'b1;
      end else if (out_take_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end
endmodule

@@ rtl/core/quantized_switch_scheduler_top.sv @@
// Channel   | handshake        | beat
// input     | push / full      | request, transport tick, take flag
// result    | empty / pop      | ready switch, armed flag, due time
// config    | cfg_we_i         | sample_rate, no read-back
// In the back end an armed tick runs the 64-step serial divider for the beat
// length, the bar length (bar-quantized only) and the remainder, then applies;
// other ticks go straight to apply. A two-entry queue splits the front from the
// back and one output register holds the result, so either side may stall.
// Reset restores sample_rate 48000, disarms and clears the ready slot.
// Depends on qss_pkg, qss_front, qss_back, qss_div.
module quantized_switch_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [18:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        req_valid_i,
  input  logic [15:0] req_target_i,
  input  logic [1:0]  req_quant_i,
  input  logic [47:0] sample_time_i,
  input  logic        playing_i,
  input  logic [15:0] tempo_bpm_i,
  input  logic [7:0]  sig_num_i,
  input  logic [7:0]  sig_den_i,
  input  logic        take_ready_i,
  output logic        empty,
  input  logic        pop,
  output logic        ready_valid_o,
  output logic [15:0] ready_target_o,
  output logic        is_armed_o,
  output logic [47:0] due_time_o
);
  import qss_pkg::*;
  logic [18:0] rate_q;
  logic        qv, qpop, ov;
  tick_t       qt;

  // Hold the sample rate; the user must write configuration only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rate_q <= DefaultRate;
    else if (cfg_we_i) rate_q <= cfg_wdata_i;
  end

  qss_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .req_valid_i, .req_target_i, .req_quant_i, .sample_time_i, .playing_i,
    .tempo_bpm_i, .sig_num_i, .sig_den_i, .take_ready_i,
    .q_valid_o(qv), .q_tick_o(qt), .q_pop_i(qpop)
  );

  qss_back u_back (
    .clk_i, .rst_ni, .rate_i(rate_q),
    .q_valid_i(qv), .q_tick_i(qt), .q_pop_o(qpop),
    .out_valid_o(ov), .ready_target_o, .is_armed_o, .due_time_o,
    .out_take_i(pop && ov)
  );

  assign empty = !ov;
  // Report ready whenever the slot holds a real pattern.
  assign ready_valid_o = (ready_target_o != NoPattern);
endmodule

@@ rtl/core/qss_checker.sv @@
// Port-level checker for the scheduler, bound to the top level.
// Depends on qss_pkg.
module qss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        ready_valid_o,
  input logic [15:0] ready_target_o,
  input logic        is_armed_o,
  input logic [47:0] due_time_o
);
  import qss_pkg::*;
  a_idle_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !ready_valid_o |-> ready_target_o == NoPattern) else $error("target");
  a_idle_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !is_armed_o |-> due_time_o == '0) else $error("due");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(due_time_o)) else $error("hold");
endmodule

bind quantized_switch_scheduler_top qss_checker u_chk (.*);

@@ tb/sv/quantized_switch_scheduler_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for quantized_switch_scheduler_top: directed table, then
// random transport ticks under four idling patterns and several sample rates.
// Depends on qss_pkg and the scheduler RTL.
module quantized_switch_scheduler_top_tb;
  import qss_pkg::*;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned RandomItems = 840;

  typedef struct {
    logic                req_valid;
    logic [PidBits-1:0]  target;
    quant_e              quant;
    logic [TimeBits-1:0] now;
    logic                playing;
    logic [15:0]         tempo;
    logic [7:0]          num;
    logic [7:0]          den;
    logic                take;
  } tick_s;

  typedef struct {
    logic                rdy;
    logic [PidBits-1:0]  rdy_target;
    logic                armed;
    logic [TimeBits-1:0] due;
  } switch_s;

  // Directed row: tick plus an optional hand-typed expectation.
  typedef struct {
    tick_s   tick;
    logic    typed;
    switch_s res;
  } row_s;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RateBits-1:0] cfg_wdata_i = '0;
  logic push = 1'b0;
  logic full;
  logic req_valid_i = 1'b0;
  logic [15:0] req_target_i = '0;
  logic [1:0] req_quant_i = '0;
  logic [47:0] sample_time_i = '0;
  logic playing_i = 1'b0;
  logic [15:0] tempo_bpm_i = '0;
  logic [7:0] sig_num_i = '0;
  logic [7:0] sig_den_i = '0;
  logic take_ready_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic ready_valid_o;
  logic [15:0] ready_target_o;
  logic is_armed_o;
  logic [47:0] due_time_o;

  always #1 clk_i = ~clk_i;

  quantized_switch_scheduler_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .push(push), .full(full),
    .req_valid_i(req_valid_i), .req_target_i(req_target_i), .req_quant_i(req_quant_i),
    .sample_time_i(sample_time_i), .playing_i(playing_i), .tempo_bpm_i(tempo_bpm_i),
    .sig_num_i(sig_num_i), .sig_den_i(sig_den_i), .take_ready_i(take_ready_i),
    .empty(empty), .pop(pop),
    .ready_valid_o(ready_valid_o), .ready_target_o(ready_target_o),
    .is_armed_o(is_armed_o), .due_time_o(due_time_o)
  );

  // Scheduler mirror: register and switch state.
  logic [RateBits-1:0] rate_q;
  logic                armed_q;
  logic [PidBits-1:0]  pend_q;
  logic [TimeBits-1:0] due_q;
  logic [PidBits-1:0]  slot_q;

  switch_s due_switches[$];
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned switches_seen = 0;
  int unsigned fires_seen = 0;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned quiet_cycles = 0;

  // Beat or bar length in samples, with the zero-means-default rules.
  function automatic logic [63:0] quantum_samples(tick_s t);
    logic [63:0] rate, tmp, n, d, beat, bar;
    rate = (rate_q == '0) ? 64'(DefaultRate) : 64'(rate_q);
    tmp  = (t.tempo == '0) ? 64'(DefaultTempo) : 64'(t.tempo);
    n    = (t.num == '0) ? 64'd4 : 64'(t.num);
    d    = (t.den == '0) ? 64'd4 : 64'(t.den);
    beat = (2 * rate * 64'd3840 + tmp) / (2 * tmp);
    if (beat < 1) beat = 1;
    if (t.quant == QUANT_BEAT) return beat;
    bar = (beat * n * 64'd4) / d;
    return (bar < 1) ? 64'd1 : bar;
  endfunction

  // Round up to the next boundary, saturating at the top of the time range.
  function automatic logic [TimeBits-1:0] next_boundary(logic [TimeBits-1:0] now,
                                                        logic [63:0] q);
    logic [63:0] rem, add;
    if (q <= 1) return now;
    rem = 64'(now) % q;
    if (rem == 0) return now;
    add = q - rem;
    if (add > 64'(TimeMax - now)) return TimeMax;
    return now + add[TimeBits-1:0];
  endfunction

  // Advance the mirror by one tick and return the switch status it reports.
  function automatic switch_s schedule_tick(tick_s t);
    switch_s r;
    if (t.req_valid) begin
      if (t.target == NoPattern) begin
        armed_q = 1'b0; pend_q = NoPattern; slot_q = NoPattern;
      end else if (t.quant == QUANT_NONE || !t.playing) begin
        armed_q = 1'b0; pend_q = NoPattern; slot_q = t.target;
      end else begin
        due_q = next_boundary(t.now, quantum_samples(t));
        pend_q = t.target;
        armed_q = 1'b1;
      end
    end
    if (armed_q && t.now >= due_q) begin
      slot_q = pend_q; armed_q = 1'b0; pend_q = NoPattern;
    end
    r.rdy = (slot_q != NoPattern);
    r.rdy_target = slot_q;
    r.armed = armed_q;
    r.due = armed_q ? due_q : '0;
    if (t.take) slot_q = NoPattern;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t ERROR %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // Send one tick: optional idle gap, then hold push until the beat is taken.
  task automatic send_tick(tick_s t, logic typed, switch_s typed_res);
    switch_s r;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_valid_i <= t.req_valid; req_target_i <= t.target; req_quant_i <= t.quant;
    sample_time_i <= t.now; playing_i <= t.playing; tempo_bpm_i <= t.tempo;
    sig_num_i <= t.num; sig_den_i <= t.den; take_ready_i <= t.take;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    // Predict at acceptance; typed rows still advance the mirror.
    r = schedule_tick(t);
    due_switches.push_back(typed ? typed_res : r);
    ticks_sent++;
  endtask

  // Drain outstanding results, let the back end settle, then write the rate.
  task automatic write_rate(logic [RateBits-1:0] v);
    push <= 1'b0;
    wait (due_switches.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_q = v;
  endtask

  // Result side: check the beat taken at this edge, then pick the next pop.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (due_switches.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(ready_target_o), 64'(NoPattern));
      end else begin
        switch_s w;
        w = due_switches.pop_front();
        if (ready_valid_o !== w.rdy)
          report_mismatch("ready_valid", 64'(ready_valid_o), 64'(w.rdy));
        if (ready_target_o !== w.rdy_target)
          report_mismatch("ready_target", 64'(ready_target_o), 64'(w.rdy_target));
        if (is_armed_o !== w.armed)
          report_mismatch("is_armed", 64'(is_armed_o), 64'(w.armed));
        if (due_time_o !== w.due) report_mismatch("due_time", 64'(due_time_o), 64'(w.due));
        if (w.rdy) switches_seen++;
        if (w.armed) fires_seen++;
      end
    end
    pop <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog: abort when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("quantized_switch_scheduler_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_s mk(logic rv, logic [15:0] tg, quant_e q, logic [47:0] now,
                               logic pl, logic [15:0] tp, logic [7:0] n, logic [7:0] d,
                               logic tk);
    tick_s t;
    t.req_valid = rv; t.target = tg; t.quant = q; t.now = now; t.playing = pl;
    t.tempo = tp; t.num = n; t.den = d; t.take = tk;
    return t;
  endfunction

  function automatic switch_s sw(logic rv, logic [15:0] tg, logic ar, logic [47:0] du);
    switch_s s;
    s.rdy = rv; s.rdy_target = tg; s.armed = ar; s.due = du;
    return s;
  endfunction

  // Random tick: mostly well-formed transport runs, some noise.
  logic [TimeBits-1:0] run_time = '0;
  function automatic tick_s random_tick();
    tick_s t;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) run_time = 48'({$urandom(), $urandom()});
    else if (pick < 8) run_time = TimeMax - 48'($urandom_range(100000));
    else run_time = run_time + 48'($urandom_range(20000));
    t.now = run_time;
    t.req_valid = ($urandom_range(99) < 35);
    t.target = ($urandom_range(99) < 8) ? NoPattern : 16'($urandom());
    t.quant = quant_e'($urandom_range(3));
    t.playing = ($urandom_range(99) < 85);
    pick = $urandom_range(99);
    t.tempo = (pick < 20) ? 16'd0 : (pick < 80) ? 16'($urandom_range(3000, 20000))
                                                : 16'($urandom());
    t.num = ($urandom_range(99) < 60) ? 8'($urandom_range(0, 7)) : 8'($urandom());
    t.den = ($urandom_range(99) < 60) ? 8'($urandom_range(0, 8)) : 8'($urandom());
    t.take = ($urandom_range(99) < 40);
    return t;
  endfunction

  row_s rows[$];
  logic [RateBits-1:0] rates[4] = '{19'd0, 19'd1, 19'd384000, 19'h7FFFF};
  int unsigned idles[4] = '{0, 59, 0, 31};
  int unsigned stalls[4] = '{0, 0, 59, 31};

  initial begin
    rate_q = DefaultRate; armed_q = 1'b0; pend_q = NoPattern; due_q = '0; slot_q = NoPattern;
    // Default rate 48000 at 120 bpm: beat 24000, 4/4 bar 96000.
    rows = '{
      '{mk(1'b0, 16'h0000, QUANT_NONE, 48'd0, 1'b0, 16'd0, 8'd0, 8'd0, 1'b0), 1'b1,
        sw(1'b0, NoPattern, 1'b0, 48'd0)},
      '{mk(1'b1, 16'h0005, QUANT_NONE, 48'd10, 1'b1, 16'd0, 8'd0, 8'd0, 1'b1), 1'b1,
        sw(1'b1, 16'h0005, 1'b0, 48'd0)},
      '{mk(1'b0, 16'h0000, QUANT_NONE, 48'd20, 1'b1, 16'd0, 8'd0, 8'd0, 1'b0), 1'b1,
        sw(1'b0, NoPattern, 1'b0, 48'd0)},
      '{mk(1'b1, 16'h0007, QUANT_BEAT, 48'd1000, 1'b1, 16'd0, 8'd0, 8'd0, 1'b0), 1'b1,
        sw(1'b0, NoPattern, 1'b1, 48'd24000)},
      '{mk(1'b0, 16'h0000, QUANT_NONE, 48'd23999, 1'b1, 16'd0, 8'd0, 8'd0, 1'b0), 1'b1,
        sw(1'b0, NoPattern, 1'b1, 48'd24000)},
      '{mk(1'b0, 16'h0000, QUANT_NONE, 48'd24000, 1'b1, 16'd0, 8'd0, 8'd0, 1'b1), 1'b1,
        sw(1'b1, 16'h0007, 1'b0, 48'd0)},
      '{mk(1'b1, 16'h0009, QUANT_BAR, 48'd0, 1'b1, 16'd0, 8'd0, 8'd0, 1'b0), 1'b1,
        sw(1'b1, 16'h0009, 1'b0, 48'd0)},
      '{mk(1'b1, NoPattern, QUANT_BAR, 48'd5, 1'b1, 16'd0, 8'd0, 8'd0, 1'b0), 1'b1,
        sw(1'b0, NoPattern, 1'b0, 48'd0)},
      '{mk(1'b1, 16'h0003, QUANT_BAR, 48'd100, 1'b1, 16'd0, 8'd0, 8'd0, 1'b0), 1'b1,
        sw(1'b0, NoPattern, 1'b1, 48'd96000)},
      '{mk(1'b1, 16'h0000, QUANT_BEAT, 48'd200, 1'b0, 16'd0, 8'd0, 8'd0, 1'b1), 1'b1,
        sw(1'b1, 16'h0000, 1'b0, 48'd0)},
      '{mk(1'b0, 16'h0000, QUANT_NONE, 48'd300, 1'b1, 16'd0, 8'd0, 8'd0, 1'b1), 1'b1,
        sw(1'b0, NoPattern, 1'b0, 48'd0)},
      '{mk(1'b1, 16'h1234, QUANT_BAR3, 48'd777, 1'b1, 16'hFFFF, 8'hFF, 8'h01, 1'b0), 1'b0,
        '{default: 0}},
      '{mk(1'b1, 16'hFFFE, QUANT_BAR, TimeMax - 48'd16, 1'b1, 16'd1, 8'd0, 8'hFF, 1'b0), 1'b0,
        '{default: 0}},
      '{mk(1'b0, 16'h0000, QUANT_NONE, TimeMax, 1'b1, 16'd0, 8'd0, 8'd0, 1'b1), 1'b0,
        '{default: 0}},
      '{mk(1'b1, 16'hAAAA, QUANT_BEAT, 48'hAAAA_AAAA_AAAA, 1'b1, 16'h5555, 8'hAA, 8'h55, 1'b1),
        1'b0, '{default: 0}},
      '{mk(1'b1, 16'h5555, QUANT_BAR, 48'h5555_5555_5555, 1'b1, 16'hAAAA, 8'h55, 8'hAA, 1'b0),
        1'b0, '{default: 0}},
      '{mk(1'b0, 16'h0000, QUANT_NONE, TimeMax, 1'b1, 16'd0, 8'd0, 8'd0, 1'b1), 1'b0,
        '{default: 0}}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (rows[i]) send_tick(rows[i].tick, rows[i].typed, rows[i].res);

    // Random phases, each at its own rate and idling pattern; drain between them.
    for (int p = 0; p < 4; p++) begin
      write_rate(rates[p]);
      send_idle = idles[p];
      recv_stall = stalls[p];
      for (int i = 0; i < RandomItems / 5; i++) send_tick(random_tick(), 1'b0, '{default: 0});
    end
    write_rate(19'd48000);
    send_idle = 0;
    recv_stall = 0;
    for (int i = 0; i < RandomItems / 5; i++) send_tick(random_tick(), 1'b0, '{default: 0});
    push <= 1'b0;

    wait (due_switches.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d ticks over five sample rates and four idling patterns;", ticks_sent);
    $display("%0d results reported a ready switch, %0d an armed one.", switches_seen, fires_seen);
    if (errors == 0) begin
      $display("quantized_switch_scheduler_top: match");
    end else begin
      $display("quantized_switch_scheduler_top: mismatch");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/qss_pkg.sv
rtl/core/qss_front.sv
rtl/core/qss_div.sv
rtl/core/qss_back.sv
rtl/core/quantized_switch_scheduler_top.sv
rtl/core/qss_checker.sv
tb/sv/quantized_switch_scheduler_top_tb.sv
